### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// ante implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/mit_pkg.sv
// ----------------------------------------------------------------------------
// mit_pkg
// Shared types and constants of the multiplexed interval timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mit_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int DELAY_BITS = 23;
  localparam int TIME_W     = 32;
  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 3;
  localparam int TICKS_W    = 23;
  localparam int CFG_W      = 8;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // stream packing
  localparam int IN_TDATA_W  = 32;  // timer_id, ticks, pad
  localparam int OUT_TDATA_W = 40;  // slot, elapsed, pad

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_FIRE  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FIRE
  } back_state_t;

  // decoded command as held in the queue
  typedef struct packed {
    cmd_e                  op;
    logic                  id_ok;
    logic [SLOT_W-1:0]     id;
    logic [IDX_W-1:0]      idx;
    logic [DELAY_BITS-1:0] ticks;
  } cmd_t;

  // back-end handshake toward the queue
  typedef struct packed {
    logic pop;
    logic busy;
  } back_sts_t;

endpackage

### rtl/core/multiplexed_interval_timer.sv
// ----------------------------------------------------------------------------
// multiplexed_interval_timer
// Eight virtual timers on one shared tick-driven time base.
// ----------------------------------------------------------------------------
// Commands enter on s_axis (tuser = cmd, tdata = timer_id, ticks): tick, arm,
// disarm, query. Results leave on m_axis (tuser = kind, tdata = slot,
// elapsed, tlast marks the last result of a command). cfg_data writes the
// autoload mask; cfg_ready is always high, write only while the block idles.
// A two-entry command queue sits in front of the executing back end, so
// s_axis keeps accepting while a result waits on m_axis.
// Arm and disarm retire from the idle state; a query retires there once
// the result register is free, its reply shows on m_axis the next cycle.
// A tick advances the time base, then checks all slots for due timers,
// then emits one fire result per due timer, lowest slot first.
// When m_axis stalls, the result register holds and the back end waits
// at its next query or fire; the queue then fills and s_axis_tready drops.
// Reset clears time, expiry times, periods, armed flags and the mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module multiplexed_interval_timer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] timer_id, [25:3] ticks, rest zero
  input  logic [mit_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [mit_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] slot, [34:3] elapsed, rest zero
  output logic [mit_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] kind
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mit_pkg::CFG_W-1:0]       cfg_data
);
  import mit_pkg::*;

  logic              q_valid;
  cmd_t              q_data;
  back_sts_t         sts;
  logic              res_query;
  logic              res_fire;
  logic [TIME_W-1:0] res_elapsed;

  assign cfg_ready = 1'b1;

  mit_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (sts.pop)
  );

  mit_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .sts           (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign res_query   = m_axis_tvalid && m_axis_tuser;
  assign res_fire    = m_axis_tvalid && !m_axis_tuser;
  assign res_elapsed = m_axis_tdata[SLOT_W +: TIME_W];

  `ASSERT_IMPLIES(a_pop_needs_entry, clk, rst, sts.pop, q_valid, "pop from empty queue")
  `ASSERT_IMPLIES(a_no_pop_busy, clk, rst, sts.busy, !sts.pop, "pop during tick scan")
  `ASSERT_IMPLIES(a_query_last, clk, rst, res_query, m_axis_tlast, "query reply not last")
  `ASSERT_IMPLIES(a_fire_zero, clk, rst, res_fire, res_elapsed == '0, "fire elapsed nonzero")

endmodule

### rtl/core/mit_front.sv
// ----------------------------------------------------------------------------
// mit_front
// Accepts commands, decodes them and buffers them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mit_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] timer_id, [25:3] ticks, rest zero
  input  logic [mit_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [mit_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                           q_valid,
  output mit_pkg::cmd_t                  q_data,
  input  logic                           q_pop
);
  import mit_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  cmd_t              dec;
  logic [DELAY_BITS-1:0] raw_ticks;

  // decode: range check of the slot, zero delay raised to one
  always_comb begin
    raw_ticks = s_axis_tdata[SLOT_W +: DELAY_BITS];
    dec.op    = cmd_e'(s_axis_tuser);
    dec.id    = s_axis_tdata[SLOT_W-1:0];
    dec.idx   = IDX_W'(s_axis_tdata[SLOT_W-1:0]);
    dec.id_ok = (32'(s_axis_tdata[SLOT_W-1:0]) < 32'(NUM_TIMERS));
    dec.ticks = (raw_ticks == '0) ? DELAY_BITS'(1) : raw_ticks;
  end

  assign s_axis_tready = (count != QCNT_W'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign q_data        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/mit_back.sv
// ----------------------------------------------------------------------------
// mit_back
// Executes commands: time base, per-slot expiry state, fire scan, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mit_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [mit_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            q_valid,
  input  mit_pkg::cmd_t                   q_data,
  output mit_pkg::back_sts_t              sts,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] slot, [34:3] elapsed, rest zero
  output logic [mit_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] kind
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import mit_pkg::*;

  localparam int AUTO_N = (NUM_TIMERS < CFG_W) ? NUM_TIMERS : CFG_W;

  back_state_t state;
  back_state_t state_next;

  logic [CFG_W-1:0]      autoload;
  logic [TIME_W-1:0]     cur_time;
  logic [TIME_W-1:0]     expiry [NUM_TIMERS];
  logic [DELAY_BITS-1:0] period [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed;
  logic [NUM_TIMERS-1:0] due;

  logic                  out_valid;
  kind_e                 out_kind;
  logic [SLOT_W-1:0]     out_slot;
  logic [TIME_W-1:0]     out_elapsed;
  logic                  out_last;

  logic                  out_free;
  logic                  do_tick;
  logic                  do_arm;
  logic                  do_disarm;
  logic                  do_query;
  logic                  fire_go;
  logic                  pop;

  logic [NUM_TIMERS-1:0] due_calc;
  logic [NUM_TIMERS-1:0] auto_ext;
  logic [NUM_TIMERS-1:0] sel_hot;
  logic [NUM_TIMERS-1:0] due_rest;
  logic [IDX_W-1:0]      sel;
  logic [TIME_W-1:0]     diff;
  logic [TIME_W-1:0]     query_el;
  logic [TIME_W-1:0]     el_raw;

  assign out_free = !out_valid || m_axis_tready;

  // due check against the already advanced time, signed wrap-aware
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      diff        = cur_time - expiry[i];
      due_calc[i] = armed[i] && !diff[TIME_W-1];
    end
  end

  always_comb begin
    auto_ext = '0;
    for (int i = 0; i < AUTO_N; i++) begin
      auto_ext[i] = autoload[i];
    end
  end

  // lowest pending slot fires first
  always_comb begin
    sel     = '0;
    sel_hot = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (due[i]) begin
        sel     = IDX_W'(i);
        sel_hot = NUM_TIMERS'(1) << i;
      end
    end
    due_rest = due & ~sel_hot;
  end

  always_comb begin
    el_raw   = cur_time - expiry[q_data.idx];
    query_el = (!q_data.id_ok || el_raw[TIME_W-1]) ? '0 : el_raw;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_data.op == CMD_TICK) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = (due_calc != '0) ? ST_FIRE : ST_IDLE;
      end
      ST_FIRE: begin
        if (out_free && due_rest == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    do_tick   = 1'b0;
    do_arm    = 1'b0;
    do_disarm = 1'b0;
    do_query  = 1'b0;
    fire_go   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_data.op)
            CMD_TICK: begin
              pop     = 1'b1;
              do_tick = 1'b1;
            end
            CMD_ARM: begin
              pop    = 1'b1;
              do_arm = q_data.id_ok;
            end
            CMD_DISARM: begin
              pop       = 1'b1;
              do_disarm = q_data.id_ok;
            end
            CMD_QUERY: begin
              pop      = out_free;
              do_query = out_free;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_FIRE: fire_go = out_free;
      default: ;
    endcase
  end

  assign sts.pop  = pop;
  assign sts.busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      autoload <= '0;
      cur_time <= '0;
      armed    <= '0;
      due      <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        expiry[i] <= '0;
        period[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        autoload <= cfg_data;
      end
      if (do_tick) begin
        cur_time <= cur_time + 1'b1;
      end
      if (do_arm) begin
        expiry[q_data.idx] <= cur_time + TIME_W'(q_data.ticks);
        period[q_data.idx] <= q_data.ticks;
        armed[q_data.idx]  <= 1'b1;
      end
      if (do_disarm) begin
        armed[q_data.idx] <= 1'b0;
      end
      if (state == ST_EVAL) begin
        due <= due_calc;
      end
      if (fire_go) begin
        due <= due_rest;
        if (auto_ext[sel]) begin
          expiry[sel] <= expiry[sel] + TIME_W'(period[sel]);
        end else begin
          armed[sel] <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire_go || do_query) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_go) begin
      out_kind    <= KIND_FIRE;
      out_slot    <= SLOT_W'(sel);
      out_elapsed <= '0;
      out_last    <= (due_rest == '0);
    end else if (do_query) begin
      out_kind    <= KIND_QUERY;
      out_slot    <= q_data.id;
      out_elapsed <= query_el;
      out_last    <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {(OUT_TDATA_W - SLOT_W - TIME_W)'(0), out_elapsed, out_slot};

endmodule

### tb/multiplexed_interval_timer_tb.sv
// ----------------------------------------------------------------------------
// multiplexed_interval_timer_tb
// Self-checking bench for the multiplexed interval timer.
// ----------------------------------------------------------------------------
// Commands go in on s_axis. A built-in timer model tracks the time base,
// expiry times, periods, armed flags and the autoload mask, and queues the
// fire events and query replies that each command causes. Every m_axis
// transaction is compared field by field with the oldest queued event.
// Directed tests cover zero delay, maximum delay, ties and idle queries.
// Random traffic then runs under several sender and receiver idle patterns,
// and a long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiplexed_interval_timer_tb;
  import mit_pkg::*;

  localparam int SETTLE_CYCLES = 2 * (NUM_TIMERS + 2) + 4;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    kind_e               kind;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   elapsed;
    logic                last;
  } timer_event_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  // timer model state
  logic [TIME_W-1:0]     now_ticks;
  logic [TIME_W-1:0]     due_at [NUM_TIMERS];
  logic [DELAY_BITS-1:0] period [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed;
  logic [CFG_W-1:0]      reload_mask;

  timer_event_t timer_events[$];

  int errors       = 0;
  int idle_cycles  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;

  multiplexed_interval_timer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Apply one accepted command to the model and queue what it emits.
  task automatic model_timer_cmd(input cmd_e op, input logic [SLOT_W-1:0] id,
                                 input logic [TICKS_W-1:0] t);
    logic [TIME_W-1:0]     diff;
    logic [DELAY_BITS-1:0] delay;
    logic [NUM_TIMERS-1:0] due;
    int                    top;
    case (op)
      CMD_TICK: begin
        now_ticks = now_ticks + 1;
        top = -1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          diff = now_ticks - due_at[i];
          due[i] = armed[i] && !diff[TIME_W-1];
          if (due[i]) top = i;
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (due[i]) begin
            if (reload_mask[i]) due_at[i] = due_at[i] + TIME_W'(period[i]);
            else armed[i] = 1'b0;
            timer_events.push_back('{KIND_FIRE, SLOT_W'(i), '0, i == top});
          end
        end
      end
      CMD_ARM: begin
        if (id < NUM_TIMERS) begin
          delay = t[DELAY_BITS-1:0];
          if (delay == '0) delay = DELAY_BITS'(1);
          due_at[id] = now_ticks + TIME_W'(delay);
          period[id] = delay;
          armed[id]  = 1'b1;
        end
      end
      CMD_DISARM: begin
        if (id < NUM_TIMERS) armed[id] = 1'b0;
      end
      default: begin
        diff = '0;
        if (id < NUM_TIMERS) begin
          diff = now_ticks - due_at[id];
          if (diff[TIME_W-1]) diff = '0;
        end
        timer_events.push_back('{KIND_QUERY, id, diff, 1'b1});
      end
    endcase
  endtask

  // tvalid stays high on return so back-to-back commands need no extra edge
  task automatic send_cmd(input cmd_e op, input logic [SLOT_W-1:0] id,
                          input logic [TICKS_W-1:0] t);
    int gap;
    gap = 0;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_TDATA_W'({t, id});
    do @(posedge clk); while (!s_axis_tready);
    model_timer_cmd(op, id, t);
  endtask

  task automatic send_random_cmd();
    int                 r;
    cmd_e               op;
    logic [TICKS_W-1:0] t;
    r = $urandom_range(99);
    t = TICKS_W'($urandom());
    if (r < 40) begin
      op = CMD_TICK;
    end else if (r < 70) begin
      op = CMD_ARM;
      r = $urandom_range(99);
      if (r < 75) t = TICKS_W'($urandom_range(12));
      else if (r < 90) t = TICKS_W'($urandom_range(300));
    end else if (r < 80) begin
      op = CMD_DISARM;
    end else begin
      op = CMD_QUERY;
    end
    send_cmd(op, SLOT_W'($urandom_range(NUM_TIMERS - 1)), t);
  endtask

  // Only written with the block drained; ticks that fire nothing still
  // need time to retire, hence the settle gap.
  task automatic write_reload_mask(input logic [CFG_W-1:0] m);
    s_axis_tvalid <= 1'b0;
    while (timer_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reload_mask = m;
  endtask

  task automatic test_basic_commands();
    send_cmd(CMD_QUERY, 3'd0, '0);           // idle slot right after reset
    send_cmd(CMD_TICK, 3'd0, '0);            // nothing due
    send_cmd(CMD_QUERY, 3'd7, '0);
    send_cmd(CMD_ARM, 3'd3, '0);             // zero delay becomes one
    send_cmd(CMD_ARM, 3'd5, '1);             // longest delay
    send_cmd(CMD_QUERY, 3'd5, '0);           // expiry ahead, saturates to 0
    send_cmd(CMD_TICK, 3'd0, '1);            // slot 3 fires and disarms
    send_cmd(CMD_DISARM, 3'd6, '0);          // idle slot
    send_cmd(CMD_ARM, 3'd0, 23'd2);
    send_cmd(CMD_ARM, 3'd7, 23'd2);
    send_cmd(CMD_TICK, 3'd0, '0);
    send_cmd(CMD_TICK, 3'd0, '0);            // tie: slot 0 then slot 7
    send_cmd(CMD_QUERY, 3'd0, '0);
    send_cmd(CMD_ARM, 3'd2, 23'd1);
    send_cmd(CMD_DISARM, 3'd2, '0);
    send_cmd(CMD_TICK, 3'd0, '0);            // disarmed slot stays quiet
    send_cmd(CMD_QUERY, 3'd7, '0);
    send_cmd(CMD_DISARM, 3'd5, '0);
    send_cmd(CMD_QUERY, 3'd3, '1);
  endtask

  // all slots periodic with period one: every tick fires all of them
  task automatic test_autoload_all_slots();
    write_reload_mask('1);
    for (int i = 0; i < NUM_TIMERS; i++) send_cmd(CMD_ARM, SLOT_W'(i), '0);
    send_cmd(CMD_TICK, 3'd0, '0);
    send_cmd(CMD_TICK, 3'd0, '0);
  endtask

  task automatic test_random_traffic();
    int               tx_pct [4] = '{0, 61, 0, 19};
    int               rx_pct [4] = '{0, 0, 61, 19};
    logic [CFG_W-1:0] masks  [4] = '{8'h00, 8'hFF, 8'h5A, 8'h81};
    for (int p = 0; p < 4; p++) begin
      write_reload_mask(masks[p]);
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      repeat (55) send_random_cmd();
    end
  endtask

  task automatic test_output_backpressure();
    write_reload_mask(8'h0F);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_req  = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_cmd(CMD_QUERY, SLOT_W'(i), TICKS_W'($urandom()));
    repeat (10) send_random_cmd();
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TICK;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    now_ticks   = '0;
    armed       = '0;
    reload_mask = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      due_at[i] = '0;
      period[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_basic_commands();
    test_autoload_all_slots();
    test_random_traffic();
    test_output_backpressure();

    s_axis_tvalid <= 1'b0;
    while (timer_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: random stalls, plus a counted hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    timer_event_t      want;
    logic [SLOT_W-1:0] got_slot;
    logic [TIME_W-1:0] got_elapsed;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_slot    = m_axis_tdata[SLOT_W-1:0];
      got_elapsed = m_axis_tdata[SLOT_W +: TIME_W];
      if (timer_events.size() == 0) begin
        $error("unexpected result transaction: kind %0d slot %0d elapsed %0d",
               m_axis_tuser, got_slot, got_elapsed);
        errors++;
      end else begin
        want = timer_events.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          errors++;
        end
        if (got_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got_slot);
          errors++;
        end
        if (got_elapsed !== want.elapsed) begin
          $error("elapsed: expected %0d, got %0d", want.elapsed, got_elapsed);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // ends the run if no channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
